// ===== hdl/dnsarp_pkg.sv =====
// Shared types and constants for the DNS A-record response parser.
// No dependencies; the parser and the top level refer to this package by scoped names.
`default_nettype none

package dnsarp_pkg;

   // Datagram limits
   localparam int MAX_PACKET_DEFAULT = 1024;
   localparam logic [15:0] EXPECTED_ID_RESET = 16'h1234;

   // Byte positions inside the UDP + DNS header
   localparam int POS_ID_LOW   = 9;
   localparam int POS_FLAGS_HI = 10;
   localparam int POS_ANCOUNT  = 15;
   localparam int POS_HDR_LAST = 19;

   // Answer type, class, TTL and rdlength together
   localparam logic [7:0] FIELD_BYTES   = 8'd10;
   localparam logic [7:0] QFIXED_BYTES  = 8'd4;
   localparam logic [7:0] RDATA_BYTES   = 8'd4;
   localparam logic [7:0] K_TYPE_DONE   = 8'd1;
   localparam logic [7:0] K_CLASS_DONE  = 8'd3;
   localparam logic [7:0] K_RDLEN_DONE  = 8'd9;
   localparam logic [15:0] TYPE_A       = 16'd1;
   localparam logic [15:0] CLASS_IN     = 16'd1;
   localparam logic [15:0] RDLEN_IPV4   = 16'd4;

   // Parse phases
   localparam int PHASE_W = 4;
   localparam logic [PHASE_W-1:0] PH_HEADER = 4'd0;
   localparam logic [PHASE_W-1:0] PH_QLEN   = 4'd1;
   localparam logic [PHASE_W-1:0] PH_QSKIP  = 4'd2;
   localparam logic [PHASE_W-1:0] PH_QFIXED = 4'd3;
   localparam logic [PHASE_W-1:0] PH_AFIRST = 4'd4;
   localparam logic [PHASE_W-1:0] PH_APTR   = 4'd5;
   localparam logic [PHASE_W-1:0] PH_ALEN   = 4'd6;
   localparam logic [PHASE_W-1:0] PH_ASKIP  = 4'd7;
   localparam logic [PHASE_W-1:0] PH_FIELDS = 4'd8;
   localparam logic [PHASE_W-1:0] PH_RDATA  = 4'd9;
   localparam logic [PHASE_W-1:0] PH_DONE   = 4'd10;
   localparam logic [PHASE_W-1:0] PH_IGNORE = 4'd11;

   // Result status codes
   localparam logic [2:0] ST_FOUND     = 3'd0;
   localparam logic [2:0] ST_SHORT     = 3'd1;
   localparam logic [2:0] ST_ID_MISS   = 3'd2;
   localparam logic [2:0] ST_NOT_RESP  = 3'd3;
   localparam logic [2:0] ST_NO_ANSWER = 3'd4;
   localparam logic [2:0] ST_TRUNC     = 3'd5;
   localparam logic [2:0] ST_NOT_A     = 3'd6;
   localparam logic [2:0] ST_NONE      = 3'd0;

   typedef struct packed {
      logic [2:0]  status;
      logic [31:0] address;
   } result_type;

endpackage

`default_nettype wire

// ===== hdl/dnsarp_if.sv =====
// Valid/ready channel interfaces for the request bytes and the parse result.
// Depends on nothing; the payload mirrors the result fields of dnsarp_pkg.
`default_nettype none

interface dnsarp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface dnsarp_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [31:0] address;

   modport source (output valid, output status, output address, input ready);
   modport sink   (input valid, input status, input address, output ready);
endinterface

`default_nettype wire

// ===== hdl/dnsarp_parser.sv =====
// Per-byte DNS response parse state: header checks, name skipping, answer fields.
// Depends on dnsarp_pkg; stepped by the top level once per datagram byte.
`default_nettype none

module dnsarp_parser #(
   parameter int MAX_PACKET = dnsarp_pkg::MAX_PACKET_DEFAULT
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   step,
   input  wire logic [7:0]             data_byte,
   input  wire logic                   last_byte,
   input  wire logic [15:0]            expected_id,
   output dnsarp_pkg::result_type      result
);

   localparam int PosW = $clog2(MAX_PACKET + 1);
   localparam logic [PosW-1:0] MaxPos = PosW'(MAX_PACKET);

   logic [PosW-1:0]                   pos_ff, pos_in;
   logic [dnsarp_pkg::PHASE_W-1:0]    phase_ff, phase_in;
   logic [7:0]                        skip_ff, skip_in;
   logic [31:0]                       shift_ff, shift_in;
   logic [15:0]                       type_ff, type_in;
   logic [15:0]                       class_ff, class_in;
   logic [2:0]                        err_ff, err_in;

   logic [31:0] shift_new;
   logic [7:0]  skip_dec;
   logic [7:0]  field_k;
   logic        parse_en;

   assign shift_new = {shift_ff[23:0], data_byte};
   assign skip_dec  = skip_ff - 8'd1;
   assign field_k   = dnsarp_pkg::FIELD_BYTES - skip_ff;
   assign parse_en  = step && (pos_ff < MaxPos);

   always_comb begin
      pos_in   = pos_ff;
      phase_in = phase_ff;
      skip_in  = skip_ff;
      shift_in = shift_ff;
      type_in  = type_ff;
      class_in = class_ff;
      err_in   = err_ff;

      if (parse_en) begin
         pos_in = pos_ff + PosW'(1);
         unique case (phase_ff)
            dnsarp_pkg::PH_HEADER: begin
               shift_in = shift_new;
               if (err_ff == dnsarp_pkg::ST_NONE) begin
                  if (pos_ff == PosW'(dnsarp_pkg::POS_ID_LOW) && shift_new[15:0] != expected_id)
                     err_in = dnsarp_pkg::ST_ID_MISS;
                  if (pos_ff == PosW'(dnsarp_pkg::POS_FLAGS_HI) && !data_byte[7])
                     err_in = dnsarp_pkg::ST_NOT_RESP;
                  if (pos_ff == PosW'(dnsarp_pkg::POS_ANCOUNT) && shift_new[15:0] == 16'd0)
                     err_in = dnsarp_pkg::ST_NO_ANSWER;
               end
               if (pos_ff == PosW'(dnsarp_pkg::POS_HDR_LAST))
                  phase_in = (err_ff != dnsarp_pkg::ST_NONE) ? dnsarp_pkg::PH_IGNORE
                                                            : dnsarp_pkg::PH_QLEN;
            end
            dnsarp_pkg::PH_QLEN: begin
               if (data_byte == 8'd0) begin
                  phase_in = dnsarp_pkg::PH_QFIXED;
                  skip_in  = dnsarp_pkg::QFIXED_BYTES;
                  shift_in = '0;
               end else begin
                  phase_in = dnsarp_pkg::PH_QSKIP;
                  skip_in  = data_byte;
               end
            end
            dnsarp_pkg::PH_QSKIP: begin
               skip_in = skip_dec;
               if (skip_dec == 8'd0) phase_in = dnsarp_pkg::PH_QLEN;
            end
            dnsarp_pkg::PH_QFIXED: begin
               skip_in = skip_dec;
               if (skip_dec == 8'd0) phase_in = dnsarp_pkg::PH_AFIRST;
            end
            dnsarp_pkg::PH_AFIRST, dnsarp_pkg::PH_ALEN: begin
               // compression pointer only recognized on the first name byte
               if (phase_ff == dnsarp_pkg::PH_AFIRST && data_byte[7:6] != 2'b00) begin
                  phase_in = dnsarp_pkg::PH_APTR;
               end else if (data_byte == 8'd0) begin
                  phase_in = dnsarp_pkg::PH_FIELDS;
                  skip_in  = dnsarp_pkg::FIELD_BYTES;
                  shift_in = '0;
               end else begin
                  phase_in = dnsarp_pkg::PH_ASKIP;
                  skip_in  = data_byte;
               end
            end
            dnsarp_pkg::PH_APTR: begin
               phase_in = dnsarp_pkg::PH_FIELDS;
               skip_in  = dnsarp_pkg::FIELD_BYTES;
               shift_in = '0;
            end
            dnsarp_pkg::PH_ASKIP: begin
               skip_in = skip_dec;
               if (skip_dec == 8'd0) phase_in = dnsarp_pkg::PH_ALEN;
            end
            dnsarp_pkg::PH_FIELDS: begin
               shift_in = shift_new;
               skip_in  = skip_dec;
               if (field_k == dnsarp_pkg::K_TYPE_DONE)  type_in  = shift_new[15:0];
               if (field_k == dnsarp_pkg::K_CLASS_DONE) class_in = shift_new[15:0];
               if (field_k == dnsarp_pkg::K_RDLEN_DONE) begin
                  shift_in = '0;
                  if (type_ff == dnsarp_pkg::TYPE_A && class_ff == dnsarp_pkg::CLASS_IN &&
                      shift_new[15:0] == dnsarp_pkg::RDLEN_IPV4) begin
                     phase_in = dnsarp_pkg::PH_RDATA;
                     skip_in  = dnsarp_pkg::RDATA_BYTES;
                  end else begin
                     if (err_ff == dnsarp_pkg::ST_NONE) err_in = dnsarp_pkg::ST_NOT_A;
                     phase_in = dnsarp_pkg::PH_IGNORE;
                  end
               end
            end
            dnsarp_pkg::PH_RDATA: begin
               shift_in = shift_new;
               skip_in  = skip_dec;
               if (skip_dec == 8'd0) phase_in = dnsarp_pkg::PH_DONE;
            end
            default: begin
               // done or ignoring: hold until the marked byte
            end
         endcase
      end
   end

   // Status as seen after this byte has been parsed
   always_comb begin
      result.address = '0;
      priority if (phase_in == dnsarp_pkg::PH_HEADER) begin
         result.status = dnsarp_pkg::ST_SHORT;
      end else if (err_in != dnsarp_pkg::ST_NONE) begin
         result.status = err_in;
      end else if (phase_in == dnsarp_pkg::PH_DONE) begin
         result.status  = dnsarp_pkg::ST_FOUND;
         result.address = shift_in;
      end else begin
         result.status = dnsarp_pkg::ST_TRUNC;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (step && last_byte)) begin
         pos_ff   <= '0;
         phase_ff <= dnsarp_pkg::PH_HEADER;
         skip_ff  <= '0;
         shift_ff <= '0;
         type_ff  <= '0;
         class_ff <= '0;
         err_ff   <= dnsarp_pkg::ST_NONE;
      end else begin
         pos_ff   <= pos_in;
         phase_ff <= phase_in;
         skip_ff  <= skip_in;
         shift_ff <= shift_in;
         type_ff  <= type_in;
         class_ff <= class_in;
         err_ff   <= err_in;
      end
   end

   a_restart_after_last: assert property (@(posedge clock) disable iff (reset)
      step && last_byte |=> pos_ff == '0 && phase_ff == dnsarp_pkg::PH_HEADER)
      else $error("parser did not restart after the final byte");

   a_pos_saturates: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= MaxPos)
      else $error("byte position ran past its limit");

   a_counted_phase_nonzero: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == dnsarp_pkg::PH_QSKIP || phase_ff == dnsarp_pkg::PH_QFIXED ||
       phase_ff == dnsarp_pkg::PH_ASKIP || phase_ff == dnsarp_pkg::PH_RDATA ||
       phase_ff == dnsarp_pkg::PH_FIELDS) |-> skip_ff != 8'd0)
      else $error("counted phase entered with zero bytes left");

   a_header_only_early: assert property (@(posedge clock) disable iff (reset)
      phase_ff == dnsarp_pkg::PH_HEADER |-> pos_ff <= PosW'(dnsarp_pkg::POS_HDR_LAST))
      else $error("header phase held past the header");

   a_ignore_has_cause: assert property (@(posedge clock) disable iff (reset)
      phase_ff == dnsarp_pkg::PH_IGNORE |-> err_ff != dnsarp_pkg::ST_NONE)
      else $error("ignoring bytes without a latched fault");

endmodule

`default_nettype wire

// ===== hdl/dns_a_record_response_parser_unit.sv =====
// DNS A-record response parser: top level with input register and result register.
// Depends on dnsarp_pkg, dnsarp_req_if/dnsarp_rsp_if and dnsarp_parser.
//
// Usage:
//   req carries one UDP datagram byte per transaction (UDP header first),
//   with last_byte set on the final byte. rsp carries exactly one
//   transaction per datagram: status and, for an IN A record of length 4,
//   the IPv4 address (first byte most significant, zero otherwise).
//   csr_we/csr_wdata write the expected DNS transaction id; write it only
//   while no datagram is in flight.
// Timing:
//   Each byte lands in an input register and is parsed from there; the
//   result of the final byte is registered into the rsp register when
//   that byte is parsed. One byte is taken every cycle as long as the rsp
//   register is free or being drained in the same cycle.
// Reset:
//   Synchronous, active high. Clears the parse state and both registers'
//   valid flags; the expected id returns to 0x1234.
// Stall:
//   While rsp is held with ready low, non-final bytes keep flowing; a final
//   byte waits in the input register and req.ready drops until rsp drains.
`default_nettype none

module dns_a_record_response_parser_unit #(
   parameter int MAX_PACKET = dnsarp_pkg::MAX_PACKET_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   dnsarp_req_if.sink       req,
   dnsarp_rsp_if.source     rsp,
   input  wire logic        csr_we,
   input  wire logic [15:0] csr_wdata
);

   logic [15:0] expected_id_ff;
   logic        in_valid_ff;
   logic [7:0]  in_data_ff;
   logic        in_last_ff;
   logic        rsp_valid_ff;
   dnsarp_pkg::result_type rsp_data_ff;
   dnsarp_pkg::result_type step_result;

   logic out_free;
   logic step;

   assign out_free  = !rsp_valid_ff || rsp.ready;
   assign step      = in_valid_ff && (!in_last_ff || out_free);
   assign req.ready = !in_valid_ff || step;

   assign rsp.valid   = rsp_valid_ff;
   assign rsp.status  = rsp_data_ff.status;
   assign rsp.address = rsp_data_ff.address;

   always_ff @(posedge clock) begin
      if (reset) begin
         expected_id_ff <= dnsarp_pkg::EXPECTED_ID_RESET;
      end else if (csr_we) begin
         expected_id_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req.ready) begin
         in_valid_ff <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         in_data_ff <= req.data_byte;
         in_last_ff <= req.last_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (step && in_last_ff) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step && in_last_ff) begin
         rsp_data_ff <= step_result;
      end
   end

   dnsarp_parser #(
      .MAX_PACKET (MAX_PACKET)
   ) u_parser (
      .clock       (clock),
      .reset       (reset),
      .step        (step),
      .data_byte   (in_data_ff),
      .last_byte   (in_last_ff),
      .expected_id (expected_id_ff),
      .result      (step_result)
   );

endmodule

`default_nettype wire
